@@ rtl/core/grcwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package grcwc_pkg;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int MAP_BITS      = 5;
   localparam int MAP_DEPTH     = 1 << (2 * MAP_BITS);
   localparam int FRAC_BITS     = 16;
   localparam int WALK_LIMIT    = 2 * (1 << MAP_BITS) + 2;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 24;
   localparam int REQ_DW = 24;
   localparam int RSP_DW = 112;

   // divider: 42-bit dividend, 41-bit divisor, one quotient bit per cycle
   localparam int DIV_NW = 42;
   localparam int DIV_DW = 41;

   typedef enum logic [CSR_AW-1:0] {
      CSR_CAMERA_POS_X = 3'd0,
      CSR_CAMERA_POS_Y = 3'd1,
      CSR_VIEW_DIR_X   = 3'd2,
      CSR_VIEW_DIR_Y   = 3'd3,
      CSR_CAM_PLANE_X  = 3'd4,
      CSR_CAM_PLANE_Y  = 3'd5
   } csr_index_type;

   typedef enum logic {
      REQ_MAP_WRITE = 1'b0,
      REQ_CAST      = 1'b1
   } req_kind_type;

   typedef enum logic [20:0] {
      ST_CLEAR = 21'h000001,
      ST_IDLE  = 21'h000002,
      ST_CX    = 21'h000004,
      ST_RDX   = 21'h000008,
      ST_RDY   = 21'h000010,
      ST_DLX   = 21'h000020,
      ST_DLXW  = 21'h000040,
      ST_DLYW  = 21'h000080,
      ST_SDX   = 21'h000100,
      ST_SDY   = 21'h000200,
      ST_SDE   = 21'h000400,
      ST_WSTEP = 21'h000800,
      ST_WREAD = 21'h001000,
      ST_DIST  = 21'h002000,
      ST_DISTW = 21'h004000,
      ST_LHW   = 21'h008000,
      ST_STW   = 21'h010000,
      ST_TP0   = 21'h020000,
      ST_TP1   = 21'h040000,
      ST_TP2   = 21'h080000,
      ST_OUT   = 21'h100000
   } state_type;

endpackage
`default_nettype wire

@@ rtl/core/grid_ray_cast_wall_column.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Grid ray caster: one wall column per cast transaction.
// req channel: tuser selects map write (0) or cast (1). A map write stores one
// 4-bit cell when it is taken and returns no result. A cast walks the 32x32
// map with DDA and returns one rsp transaction (none for a column >= 320).
// csr port: six camera registers; the user must write them only while no cast
// is in flight, which the block does not enforce. A cast walks up to 66 grid
// steps; a ray that leaves the map ends its walk sooner. Five divisions run on
// one shared restoring divider; one shared 34x34 multiplier does the products,
// the column scaling by a reciprocal constant.
// req_tready is low during a cast, so a new request is taken only after the
// cast has passed its result to the output register.
// After reset the map is cleared one cell a cycle: req_tready stays low until
// all 1024 cells are cleared; csr writes are taken throughout.
// The result sits in an output register: a stalled receiver does not block
// the next cast, which waits at its end only until that register frees.
module grid_ray_cast_wall_column
   import grcwc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CSR_DW-1:0] csr_wdata,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // screen_column, cell_col, cell_row, cell_value, zero pad
   input  wire logic [REQ_DW-1:0] req_tdata,
   // req_type
   input  wire logic              req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // column_out, wall_distance, hit_side, texture_index, texture_col,
   // stripe_start, stripe_end, texture_step, texture_start, zero pad
   output logic [RSP_DW-1:0]      rsp_tdata,
   // left_map
   output logic                   rsp_tuser
);

   localparam logic [40:0] SIDE_MAX  = 41'd1 << 40;
   localparam logic [38:0] DELTA_MAX = 39'd1 << 38;
   localparam logic [40:0] DIST_MAX  = 41'd1 << 40;
   localparam logic [36:0] LINE_MAX  = 37'd1 << 36;
   localparam logic [23:0] OUT_MAX   = 24'hFFFFFF;
   localparam logic [DIV_NW-1:0] NUM_DELTA = 42'd1 << (2 * FRAC_BITS);
   localparam logic [DIV_NW-1:0] NUM_LINE  = 42'(SCREEN_HEIGHT) << (2 * FRAC_BITS);
   localparam logic [DIV_NW-1:0] NUM_STEP  = 42'd1 << 38;
   localparam logic [6:0] HALF_H = 7'(SCREEN_HEIGHT / 2);
   // 2^23 / 5 rounded up
   localparam logic [33:0] COL_RECIP = 34'd1677722;

   state_type state_ff, state_in;

   logic [23:0] pos_x_ff, pos_y_ff;
   logic [19:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   logic [9:0] clr_addr_ff, clr_addr_in;

   logic [3:0] map_mem [0:MAP_DEPTH-1];
   logic [3:0] map_rdata_ff;
   logic       mem_we;
   logic [9:0] mem_waddr, mem_raddr;
   logic [3:0] mem_wdata;

   // shared divider
   logic [DIV_DW-1:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [DIV_NW-1:0] div_quo_ff, div_quo_in;
   logic [5:0]        div_cnt_ff, div_cnt_in;
   logic              div_load, div_done;
   logic [DIV_NW-1:0] div_num_ld;
   logic [DIV_DW-1:0] div_den_ld;
   logic [DIV_NW-1:0] div_sh, div_diff;
   logic              div_ge;

   // shared multiplier
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p_ff;

   logic [8:0]         col_ff, col_in;
   logic signed [17:0] cx_ff, cx_in;
   logic signed [20:0] rd_x_ff, rd_x_in, rd_y_ff, rd_y_in;
   logic [20:0]        abs_rd_x, abs_rd_y;
   logic [38:0]        delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic [40:0]        side_x_ff, side_x_in, side_y_ff, side_y_in;
   logic signed [9:0]  cell_x_ff, cell_x_in, cell_y_ff, cell_y_in;
   logic [6:0]         walk_ff, walk_in;
   logic               hs_ff, hs_in;
   logic [3:0]         val_ff, val_in;
   logic               left_ff, left_in;
   logic [40:0]        dist_ff, dist_in;
   logic [36:0]        lh_ff, lh_in;
   logic [23:0]        step_ff, step_in;
   logic [5:0]         tx_ff, tx_in;
   logic [7:0]         start_ff, start_in, end_ff, end_in;
   logic signed [37:0] tp_ff, tp_in;
   logic [42:0]        acc_ff, acc_in;
   logic [23:0]        tpos_ff, tpos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic [16:0]        mf_x, mf_y;
   logic [41:0]        walk_sum;
   logic signed [9:0]  cell_step;
   logic signed [25:0] num;
   logic [25:0]        num_abs;
   logic [41:0]        q_capped_dist;
   logic [20:0]        lhi;
   logic [19:0]        half;
   logic [6:0]         half_cl;
   logic [15:0]        frac;
   logic [5:0]         tx_raw;
   logic [60:0]        tp_full;
   logic [44:0]        tp_res;
   logic               rd_o_neg;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // camera registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         dir_x_ff   <= 20'hF0000;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 20'd43253;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CAMERA_POS_X: pos_x_ff   <= csr_wdata;
            CSR_CAMERA_POS_Y: pos_y_ff   <= csr_wdata;
            CSR_VIEW_DIR_X:   dir_x_ff   <= csr_wdata[19:0];
            CSR_VIEW_DIR_Y:   dir_y_ff   <= csr_wdata[19:0];
            CSR_CAM_PLANE_X:  plane_x_ff <= csr_wdata[19:0];
            CSR_CAM_PLANE_Y:  plane_y_ff <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // map memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      map_rdata_ff <= map_mem[mem_raddr];
   end

   // divider step
   always_comb begin
      div_sh   = {div_rem_ff, div_quo_ff[DIV_NW-1]};
      div_diff = div_sh - {1'b0, div_den_ff};
      div_ge   = div_sh >= {1'b0, div_den_ff};
      div_done = (div_cnt_ff == 6'd0);
      if (div_load) begin
         div_rem_in = '0;
         div_quo_in = div_num_ld;
         div_den_in = div_den_ld;
         div_cnt_in = 6'(DIV_NW);
      end else if (!div_done) begin
         div_rem_in = div_ge ? div_diff[DIV_DW-1:0] : div_sh[DIV_DW-1:0];
         div_quo_in = {div_quo_ff[DIV_NW-2:0], div_ge};
         div_den_in = div_den_ff;
         div_cnt_in = div_cnt_ff - 6'd1;
      end else begin
         div_rem_in = div_rem_ff;
         div_quo_in = div_quo_ff;
         div_den_in = div_den_ff;
         div_cnt_in = div_cnt_ff;
      end
   end

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_a = $signed({14'd0, req_tdata[8:0], 11'd0});
            mul_b = $signed(COL_RECIP);
         end
         ST_RDX: begin
            mul_a = 34'(signed'(plane_x_ff));
            mul_b = 34'(cx_ff);
         end
         ST_RDY: begin
            mul_a = 34'(signed'(plane_y_ff));
            mul_b = 34'(cx_ff);
         end
         ST_SDX: begin
            mul_a = $signed({17'd0, mf_x});
            mul_b = $signed({1'b0, delta_x_ff[32:0]});
         end
         ST_SDY: begin
            mul_a = $signed({17'd0, mf_y});
            mul_b = $signed({1'b0, delta_y_ff[32:0]});
         end
         ST_STW: begin
            mul_a = $signed({2'd0, dist_ff[31:0]});
            mul_b = hs_ff ? 34'(rd_x_ff) : 34'(rd_y_ff);
         end
         ST_TP0: begin
            mul_a = $signed({15'd0, tp_ff[18:0]});
            mul_b = $signed({10'd0, step_ff});
         end
         ST_TP1: begin
            mul_a = $signed({17'd0, tp_ff[35:19]});
            mul_b = $signed({10'd0, step_ff});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   always_comb begin
      abs_rd_x = rd_x_ff[20] ? 21'(-rd_x_ff) : 21'(rd_x_ff);
      abs_rd_y = rd_y_ff[20] ? 21'(-rd_y_ff) : 21'(rd_y_ff);
      mf_x = rd_x_ff[20] ? {1'b0, pos_x_ff[15:0]} : 17'h10000 - {1'b0, pos_x_ff[15:0]};
      mf_y = rd_y_ff[20] ? {1'b0, pos_y_ff[15:0]} : 17'h10000 - {1'b0, pos_y_ff[15:0]};
      walk_sum = (side_x_ff < side_y_ff) ? {1'b0, side_x_ff} + {3'd0, delta_x_ff}
                                         : {1'b0, side_y_ff} + {3'd0, delta_y_ff};
      cell_step = ((side_x_ff < side_y_ff) ? rd_x_ff[20] : rd_y_ff[20]) ? -10'sd1 : 10'sd1;
      num = $signed({5'd0, hs_ff ? cell_y_ff[4:0] : cell_x_ff[4:0], 16'd0})
          - $signed({2'd0, hs_ff ? pos_y_ff : pos_x_ff})
          + ((hs_ff ? rd_y_ff[20] : rd_x_ff[20]) ? 26'sd65536 : 26'sd0);
      num_abs = num[25] ? 26'(-num) : 26'(num);
      q_capped_dist = (div_quo_ff > {1'b0, DIST_MAX}) ? {1'b0, DIST_MAX} : div_quo_ff;
      lhi = lh_ff[36:16];
      half = lhi[20:1];
      half_cl = (half > 20'(HALF_H)) ? HALF_H : half[6:0];
      frac = (hs_ff ? pos_x_ff[15:0] : pos_y_ff[15:0]) + mul_p_ff[31:16];
      tx_raw = frac[15:10];
      rd_o_neg = hs_ff ? rd_y_ff[20] : rd_x_ff[20];
      tp_full = {18'd0, acc_ff} + {1'b0, mul_p_ff[40:0], 19'd0} + 61'd0;
      tp_res = tp_full[60:16];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      col_in      = col_ff;
      cx_in       = cx_ff;
      rd_x_in     = rd_x_ff;
      rd_y_in     = rd_y_ff;
      delta_x_in  = delta_x_ff;
      delta_y_in  = delta_y_ff;
      side_x_in   = side_x_ff;
      side_y_in   = side_y_ff;
      cell_x_in   = cell_x_ff;
      cell_y_in   = cell_y_ff;
      walk_in     = walk_ff;
      hs_in       = hs_ff;
      val_in      = val_ff;
      left_in     = left_ff;
      dist_in     = dist_ff;
      lh_in       = lh_ff;
      step_in     = step_ff;
      tx_in       = tx_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      tp_in       = tp_ff;
      acc_in      = acc_ff;
      tpos_in     = tpos_ff;
      div_load    = 1'b0;
      div_num_ld  = '0;
      div_den_ld  = '0;
      mem_we      = 1'b0;
      mem_waddr   = {req_tdata[13:9], req_tdata[18:14]};
      mem_wdata   = req_tdata[22:19];
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = 4'd0;
            clr_addr_in = clr_addr_ff + 10'd1;
            if (clr_addr_ff == 10'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == REQ_MAP_WRITE) begin
                  mem_we = 1'b1;
               end else if (req_tdata[8:0] < 9'(SCREEN_WIDTH)) begin
                  col_in   = req_tdata[8:0];
                  state_in = ST_CX;
               end
            end
         end
         ST_CX: begin
            cx_in    = $signed({1'b0, mul_p_ff[39:23]}) - 18'sd65536;
            state_in = ST_RDX;
         end
         ST_RDX: state_in = ST_RDY;
         ST_RDY: begin
            rd_x_in  = 21'(signed'(dir_x_ff)) + $signed(mul_p_ff[36:16]);
            state_in = ST_DLX;
         end
         ST_DLX: begin
            rd_y_in    = 21'(signed'(dir_y_ff)) + $signed(mul_p_ff[36:16]);
            div_load   = 1'b1;
            div_num_ld = NUM_DELTA;
            div_den_ld = {20'd0, abs_rd_x};
            state_in   = ST_DLXW;
         end
         ST_DLXW: begin
            if (div_done) begin
               delta_x_in = (div_quo_ff > {3'd0, DELTA_MAX}) ? DELTA_MAX : div_quo_ff[38:0];
               div_load   = 1'b1;
               div_num_ld = NUM_DELTA;
               div_den_ld = {20'd0, abs_rd_y};
               state_in   = ST_DLYW;
            end
         end
         ST_DLYW: begin
            if (div_done) begin
               delta_y_in = (div_quo_ff > {3'd0, DELTA_MAX}) ? DELTA_MAX : div_quo_ff[38:0];
               state_in   = ST_SDX;
            end
         end
         ST_SDX: state_in = ST_SDY;
         ST_SDY: begin
            side_x_in = delta_x_ff[38] ? {2'd0, mf_x, 22'd0} : 41'(mul_p_ff[56:16]);
            state_in  = ST_SDE;
         end
         ST_SDE: begin
            side_y_in = delta_y_ff[38] ? {2'd0, mf_y, 22'd0} : 41'(mul_p_ff[56:16]);
            cell_x_in = $signed({2'd0, pos_x_ff[23:16]});
            cell_y_in = $signed({2'd0, pos_y_ff[23:16]});
            walk_in   = '0;
            if (pos_x_ff[23:16] >= 8'(1 << MAP_BITS)
                || pos_y_ff[23:16] >= 8'(1 << MAP_BITS)) begin
               left_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               left_in  = 1'b0;
               state_in = ST_WSTEP;
            end
         end
         ST_WSTEP: begin
            if (walk_ff == 7'(WALK_LIMIT)) begin
               left_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               walk_in = walk_ff + 7'd1;
               if (side_x_ff < side_y_ff) begin
                  hs_in     = 1'b0;
                  side_x_in = (walk_sum > {1'b0, SIDE_MAX}) ? SIDE_MAX : walk_sum[40:0];
                  cell_x_in = cell_x_ff + cell_step;
               end else begin
                  hs_in     = 1'b1;
                  side_y_in = (walk_sum > {1'b0, SIDE_MAX}) ? SIDE_MAX : walk_sum[40:0];
                  cell_y_in = cell_y_ff + cell_step;
               end
               if (cell_x_in[9] || cell_x_in >= 10'sd32
                   || cell_y_in[9] || cell_y_in >= 10'sd32) begin
                  left_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_WREAD;
               end
            end
         end
         ST_WREAD: begin
            val_in = map_rdata_ff;
            if (map_rdata_ff != 4'd0) begin
               state_in = ST_DIST;
            end else begin
               state_in = ST_WSTEP;
            end
         end
         ST_DIST: begin
            div_load   = 1'b1;
            div_num_ld = {num_abs, 16'd0};
            div_den_ld = {20'd0, hs_ff ? abs_rd_y : abs_rd_x};
            state_in   = ST_DISTW;
         end
         ST_DISTW: begin
            if (div_done) begin
               dist_in    = q_capped_dist[40:0];
               div_load   = 1'b1;
               div_num_ld = NUM_LINE;
               div_den_ld = q_capped_dist[40:0];
               state_in   = ST_LHW;
            end
         end
         ST_LHW: begin
            if (div_done) begin
               lh_in      = (div_quo_ff > {5'd0, LINE_MAX}) ? LINE_MAX : div_quo_ff[36:0];
               div_load   = 1'b1;
               div_num_ld = NUM_STEP;
               div_den_ld = (div_quo_ff > {5'd0, LINE_MAX}) ? {4'd0, LINE_MAX}
                                                            : {4'd0, div_quo_ff[36:0]};
               state_in   = ST_STW;
            end
         end
         ST_STW: begin
            if (div_done) begin
               step_in  = (div_quo_ff > {18'd0, OUT_MAX}) ? OUT_MAX : div_quo_ff[23:0];
               tx_in    = ((!hs_ff && !rd_x_ff[20] && rd_x_ff != 21'sd0)
                           || (hs_ff && rd_o_neg == 1'b0 && 1'b0)
                           || (hs_ff && rd_y_ff[20])) ? ~tx_raw : tx_raw;
               start_in = 8'(HALF_H - half_cl);
               end_in   = (half >= 20'(HALF_H)) ? 8'(SCREEN_HEIGHT)
                                                : 8'(half[6:0] + HALF_H);
               tp_in    = $signed({2'd0, lh_ff[36:1]}) - $signed({15'd0, half_cl, 16'd0});
               state_in = ST_TP0;
            end
         end
         ST_TP0: begin
            if (tp_ff[37]) begin
               tpos_in  = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_TP1;
            end
         end
         ST_TP1: begin
            acc_in   = mul_p_ff[42:0];
            state_in = ST_TP2;
         end
         ST_TP2: begin
            tpos_in  = (tp_res > {21'd0, OUT_MAX}) ? OUT_MAX : tp_res[23:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = left_ff;
               if (left_ff) begin
                  rsp_data_in = {79'd0, OUT_MAX, col_ff};
               end else begin
                  rsp_data_in = {4'd0, tpos_ff, step_ff, end_ff, start_ff, tx_ff,
                                 val_ff - 4'd1, hs_ff,
                                 (dist_ff > {17'd0, OUT_MAX}) ? OUT_MAX : dist_ff[23:0],
                                 col_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // next cell of the walk, read in time for ST_WREAD
      mem_raddr = {cell_x_in[4:0], cell_y_in[4:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      col_ff      <= col_in;
      cx_ff       <= cx_in;
      rd_x_ff     <= rd_x_in;
      rd_y_ff     <= rd_y_in;
      delta_x_ff  <= delta_x_in;
      delta_y_ff  <= delta_y_in;
      side_x_ff   <= side_x_in;
      side_y_ff   <= side_y_in;
      cell_x_ff   <= cell_x_in;
      cell_y_ff   <= cell_y_in;
      walk_ff     <= walk_in;
      hs_ff       <= hs_in;
      val_ff      <= val_in;
      left_ff     <= left_in;
      dist_ff     <= dist_in;
      lh_ff       <= lh_in;
      step_ff     <= step_in;
      tx_ff       <= tx_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      tp_ff       <= tp_in;
      acc_ff      <= acc_in;
      tpos_ff     <= tpos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/grcwc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module grcwc_checker
   import grcwc_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_DW-1:0] rsp_tdata,
   input wire logic              rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transaction changed");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:0] < 9'(SCREEN_WIDTH))
      else $error("result column out of range");

   a_left_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[32:9] == 24'hFFFFFF
                                  && rsp_tdata[107:33] == 75'd0)
      else $error("left-map result fields wrong");

   a_stripe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[51:44] <= 8'(SCREEN_HEIGHT / 2)
                                   && rsp_tdata[59:52] >= 8'(SCREEN_HEIGHT / 2)
                                   && rsp_tdata[59:52] <= 8'(SCREEN_HEIGHT))
      else $error("stripe rows out of range");

endmodule

bind grid_ray_cast_wall_column grcwc_checker u_grcwc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

@@ test/grid_ray_cast_wall_column_tb.sv @@
`timescale 1ns / 1ps
module grid_ray_cast_wall_column_tb;
   import grcwc_pkg::*;

   localparam longint ONE      = 64'd1 << FRAC_BITS;
   localparam longint DELTA_CAP = 64'd1 << 38;
   localparam longint SIDE_CAP  = 64'd1 << 40;
   localparam longint DIST_CAP  = 64'd1 << 40;
   localparam longint LINE_CAP  = 64'd1 << 36;
   localparam longint OUT_CAP   = 64'hFFFFFF;
   localparam int     TEX       = 64;
   localparam int     MAP_N     = 1 << MAP_BITS;
   localparam int     STALL_LIMIT = 20000;

   typedef struct {
      logic [8:0]  column;
      logic [23:0] distance;
      logic        side;
      logic [3:0]  tex_index;
      logic [5:0]  tex_col;
      logic [7:0]  row_start;
      logic [7:0]  row_end;
      logic [23:0] tex_step;
      logic [23:0] tex_start;
      logic        off_map;
   } wall_column_type;

   class wall_column_board;
      logic [3:0]   cells [MAP_DEPTH];
      logic [23:0]  camera [6];
      wall_column_type columns_due [$];
      int           errors, walls_seen, misses_seen;

      function new();
         foreach (cells[i]) cells[i] = '0;
         camera[0] = 0;
         camera[1] = 0;
         camera[2] = 24'h0F0000;
         camera[3] = 0;
         camera[4] = 0;
         camera[5] = 24'd43253;
         errors = 0;
         walls_seen = 0;
         misses_seen = 0;
      endfunction

      function void set_camera(csr_index_type idx, logic [23:0] value);
         camera[idx] = (idx < CSR_VIEW_DIR_X) ? value : {4'h0, value[19:0]};
      endfunction

      function longint sx20(logic [23:0] v);
         longint r;
         r = $signed(v[19:0]);
         return r;
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      function longint clip(longint v, longint m);
         return v > m ? m : v;
      endfunction

      function void note_request(req_kind_type kind, logic [8:0] col, logic [4:0] cc,
                                 logic [4:0] cr, logic [3:0] cv);
         wall_column_type e;
         longint pos[2], rd[2], delta[2], side[2], grid_pos[2], stp[2];
         longint cx, wall_dist, num, lh, lhi, start, stop, tstep, tpos, wx, tx, f;
         int hs, hit, off;
         logic [3:0] val;
         if (kind == REQ_MAP_WRITE) begin
            cells[{cc, cr}] = cv;
            return;
         end
         if (col >= SCREEN_WIDTH) return;
         hs = 0; hit = 0; off = 0; val = 0;
         cx = (longint'(col) * 2 * ONE) / SCREEN_WIDTH - ONE;
         pos[0] = camera[0];
         pos[1] = camera[1];
         rd[0] = sx20(camera[2]) + ((sx20(camera[4]) * cx) >>> FRAC_BITS);
         rd[1] = sx20(camera[3]) + ((sx20(camera[5]) * cx) >>> FRAC_BITS);
         for (int a = 0; a < 2; a++) begin
            f = pos[a] & (ONE - 1);
            grid_pos[a] = pos[a] >>> FRAC_BITS;
            delta[a] = rd[a] == 0 ? DELTA_CAP : clip((ONE * ONE) / mag(rd[a]), DELTA_CAP);
            if (rd[a] < 0) begin
               stp[a] = -1;
               side[a] = (f * delta[a]) >>> FRAC_BITS;
            end else begin
               stp[a] = 1;
               side[a] = ((ONE - f) * delta[a]) >>> FRAC_BITS;
            end
         end
         if (grid_pos[0] >= MAP_N || grid_pos[1] >= MAP_N) off = 1;
         for (int k = 0; !off && !hit && k < WALK_LIMIT; k++) begin
            int a;
            a = side[0] < side[1] ? 0 : 1;
            side[a] = clip(side[a] + delta[a], SIDE_CAP);
            grid_pos[a] += stp[a];
            hs = a;
            if (grid_pos[a] < 0 || grid_pos[a] >= MAP_N) begin
               off = 1;
               break;
            end
            val = cells[grid_pos[0] * MAP_N + grid_pos[1]];
            if (val != 0) hit = 1;
         end
         if (!hit) off = 1;
         e = '{column: col, distance: '1, side: 0, tex_index: 0, tex_col: 0,
               row_start: 0, row_end: 0, tex_step: 0, tex_start: 0, off_map: 1};
         if (!off) begin
            num = grid_pos[hs] * ONE - pos[hs] + (stp[hs] < 0 ? ONE : 0);
            wall_dist = rd[hs] == 0 ? DIST_CAP
                      : clip((mag(num) * ONE) / mag(rd[hs]), DIST_CAP);
            lh = wall_dist == 0 ? LINE_CAP
               : clip((longint'(SCREEN_HEIGHT) * ONE * ONE) / wall_dist, LINE_CAP);
            lhi = lh >>> FRAC_BITS;
            start = SCREEN_HEIGHT / 2 - lhi / 2;
            if (start < 0) start = 0;
            stop = lhi / 2 + SCREEN_HEIGHT / 2;
            if (stop >= SCREEN_HEIGHT) stop = SCREEN_HEIGHT;
            wx = pos[1 - hs] + ((wall_dist * rd[1 - hs]) >>> FRAC_BITS);
            tx = ((wx & (ONE - 1)) * TEX) >>> FRAC_BITS;
            if ((hs == 0 && rd[0] > 0) || (hs == 1 && rd[1] < 0)) tx = TEX - tx - 1;
            tstep = lh == 0 ? OUT_CAP : clip((longint'(TEX) * ONE * ONE) / lh, OUT_CAP);
            tpos = (start - SCREEN_HEIGHT / 2) * ONE + (lh >>> 1);
            tpos = tpos < 0 ? 0 : clip((tpos * tstep) >>> FRAC_BITS, OUT_CAP);
            e.distance  = clip(wall_dist, OUT_CAP);
            e.side      = hs;
            e.tex_index = val - 4'd1;
            e.tex_col   = tx[5:0];
            e.row_start = start[7:0];
            e.row_end   = stop[7:0];
            e.tex_step  = tstep[23:0];
            e.tex_start = tpos[23:0];
            e.off_map   = 0;
         end
         columns_due.push_back(e);
      endfunction

      function void check_column(wall_column_type got);
         wall_column_type e;
         if (columns_due.size() == 0) begin
            $error("unexpected result transaction for column %0d", got.column);
            errors++;
            return;
         end
         e = columns_due.pop_front();
         if (got.off_map) misses_seen++;
         else walls_seen++;
         if (got.column !== e.column) begin
            $error("column_out exp %0d got %0d", e.column, got.column); errors++;
         end
         if (got.distance !== e.distance) begin
            $error("wall_distance exp %0h got %0h", e.distance, got.distance); errors++;
         end
         if (got.side !== e.side) begin
            $error("hit_side exp %0d got %0d", e.side, got.side); errors++;
         end
         if (got.tex_index !== e.tex_index) begin
            $error("texture_index exp %0d got %0d", e.tex_index, got.tex_index); errors++;
         end
         if (got.tex_col !== e.tex_col) begin
            $error("texture_col exp %0d got %0d", e.tex_col, got.tex_col); errors++;
         end
         if (got.row_start !== e.row_start) begin
            $error("stripe_start exp %0d got %0d", e.row_start, got.row_start); errors++;
         end
         if (got.row_end !== e.row_end) begin
            $error("stripe_end exp %0d got %0d", e.row_end, got.row_end); errors++;
         end
         if (got.tex_step !== e.tex_step) begin
            $error("texture_step exp %0h got %0h", e.tex_step, got.tex_step); errors++;
         end
         if (got.tex_start !== e.tex_start) begin
            $error("texture_start exp %0h got %0h", e.tex_start, got.tex_start); errors++;
         end
         if (got.off_map !== e.off_map) begin
            $error("left_map exp %0d got %0d", e.off_map, got.off_map); errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_we = 0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic              req_tuser = 0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              rsp_tuser;

   wall_column_board board = new();
   bit  calm = 0;
   int  hold_cycles = 0;
   int  quiet_cycles = 0;
   int  casts_sent = 0, writes_sent = 0;

   grid_ray_cast_wall_column uut (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready = 0;
      end else begin
         rsp_tready = calm ? 1'b1 : ($urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_column('{column: rsp_tdata[8:0], distance: rsp_tdata[32:9],
                              side: rsp_tdata[33], tex_index: rsp_tdata[37:34],
                              tex_col: rsp_tdata[43:38], row_start: rsp_tdata[51:44],
                              row_end: rsp_tdata[59:52], tex_step: rsp_tdata[83:60],
                              tex_start: rsp_tdata[107:84], off_map: rsp_tuser});
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_request(req_kind_type kind, logic [8:0] col, logic [4:0] cc,
                               logic [4:0] cr, logic [3:0] cv);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser  = kind;
      req_tdata  = {1'b0, cv, cr, cc, col};
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, col, cc, cr, cv);
      if (kind == REQ_CAST) casts_sent++;
      else writes_sent++;
   endtask

   task automatic cast(logic [8:0] col);
      send_request(REQ_CAST, col, $urandom, $urandom, $urandom);
   endtask

   task automatic put_cell(int x, int y, int v);
      send_request(REQ_MAP_WRITE, $urandom, x, y, v);
   endtask

   task automatic write_csr(csr_index_type idx, logic [23:0] value);
      @(negedge clock);
      req_tvalid = 0;
      csr_we = 1;
      csr_addr = idx;
      csr_wdata = value;
      board.set_camera(idx, value);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      wait (board.columns_due.size() == 0);
      repeat (500) @(posedge clock);
   endtask

   task automatic set_view(logic [23:0] px, logic [23:0] py, logic [23:0] dx,
                           logic [23:0] dy, logic [23:0] qx, logic [23:0] qy);
      drain();
      write_csr(CSR_CAMERA_POS_X, px);
      write_csr(CSR_CAMERA_POS_Y, py);
      write_csr(CSR_VIEW_DIR_X, dx);
      write_csr(CSR_VIEW_DIR_Y, dy);
      write_csr(CSR_CAM_PLANE_X, qx);
      write_csr(CSR_CAM_PLANE_Y, qy);
   endtask

   function automatic logic [23:0] near_unit();
      int v;
      v = $urandom_range(262143) - 131072;
      return v;
   endfunction

   function automatic logic [23:0] inside_pos();
      return $urandom_range(31 * 65536 - 1, 65536);
   endfunction

   task automatic random_mix(int count);
      for (int i = 0; i < count; i++) begin
         int r;
         r = $urandom_range(99);
         if (r < 60) cast($urandom_range(SCREEN_WIDTH - 1));
         else if (r < 65) cast($urandom_range(511, SCREEN_WIDTH));
         else if (r < 68) put_cell($urandom_range(31), $urandom_range(1) * 31, $urandom);
         else put_cell($urandom_range(30, 1), $urandom_range(30, 1),
                       $urandom_range(99) < 40 ? 0 : $urandom_range(15));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // default camera sits in corner cell, rays leave the map
      cast(0);
      cast(SCREEN_WIDTH - 1);
      cast(SCREEN_WIDTH / 2);
      cast(SCREEN_WIDTH);
      cast(511);
      put_cell(0, 0, 15);
      put_cell(31, 31, 1);
      put_cell(0, 31, 8);
      put_cell(31, 0, 7);
      put_cell(1, 0, 2);
      put_cell(0, 1, 3);
      cast(0);
      cast(SCREEN_WIDTH / 2);
      // camera off the map, zero ray, extreme directions
      set_view(24'hFFFFFF, 24'hFFFFFF, 24'h080000, 24'h07FFFF, 24'h07FFFF, 24'h080000);
      cast(7);
      set_view(24'h000000, 24'h000000, 24'h07FFFF, 24'h07FFFF, 0, 0);
      cast(SCREEN_WIDTH / 2);
      cast(1);
      set_view(24'h008000, 24'h008000, 0, 0, 0, 24'h010000);
      cast(SCREEN_WIDTH / 2);
      cast(SCREEN_WIDTH - 1);

      // enclose the map with walls
      for (int i = 0; i < MAP_N; i++) begin
         put_cell(i, 0, $urandom_range(15, 1));
         put_cell(i, 31, $urandom_range(15, 1));
         put_cell(0, i, $urandom_range(15, 1));
         put_cell(31, i, $urandom_range(15, 1));
      end

      set_view(24'h108000, 24'h100000, 24'hFF0000, 0, 0, 24'd43253);
      hold_cycles = 4000;
      random_mix(40);
      set_view(inside_pos(), inside_pos(), 24'h07FFFF, 24'h080000, 24'h080000, 24'h07FFFF);
      random_mix(20);
      set_view(24'h010000, 24'h1FFFFF, 24'h000001, 24'hFFFFFF, 24'h000001, 0);
      random_mix(20);
      calm = 1;
      set_view(inside_pos(), inside_pos(), near_unit(), near_unit(), near_unit(), near_unit());
      random_mix(60);
      calm = 0;
      for (int p = 0; p < 4; p++) begin
         set_view(inside_pos(), inside_pos(), $urandom, $urandom, $urandom, $urandom);
         random_mix(20);
         set_view(inside_pos(), inside_pos(), near_unit(), near_unit(),
                  near_unit(), near_unit());
         random_mix(40);
      end

      drain();
      $display("%0d casts and %0d map writes sent; %0d wall hits, %0d rays off the map",
               casts_sent, writes_sent, board.walls_seen, board.misses_seen);
      if (board.errors == 0 && board.columns_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/grcwc_pkg.sv
rtl/core/grid_ray_cast_wall_column.sv
rtl/core/grcwc_checker.sv
test/grid_ray_cast_wall_column_tb.sv
